// ===== rtl/core/iasp_pkg.sv =====
// Shared types, constants and codes for the IMAP astring parser.
package iasp_pkg;

  localparam int LENGTH_BITS  = 32;
  localparam int LEN_OUT_BITS = 32;
  localparam int WIDE_BITS    = LENGTH_BITS + 4;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] ATOM_LO   = 8'd33;
  localparam logic [7:0] ATOM_HI   = 8'd127;

  typedef enum logic [3:0] {
    CLS_OTHER,
    CLS_LBRACE,
    CLS_RBRACE,
    CLS_PLUS,
    CLS_QUOTE,
    CLS_BSLASH,
    CLS_DIGIT,
    CLS_NUL,
    CLS_CRLF
  } cls_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START,
    PH_LIT_FIRST,
    PH_LIT_DIGITS,
    PH_LIT_CLOSE,
    PH_LIT_PLUS,
    PH_LIT_DATA,
    PH_QUOTED,
    PH_QUOTED_ESC,
    PH_ATOM
  } phase_t;

  typedef enum logic [1:0] {
    ST_MORE = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       start_req;
    logic       list_mode;
    cls_t       cls;
    logic [3:0] digit;
    logic       atom_strict;
    logic       atom_list_only;
  } item_t;

endpackage

// ===== rtl/core/imap_astring_parser.sv =====
// Top level of the IMAP astring parser: front end, queue and back end.
// The parser takes one byte per clock and gives one result per byte, in order, at a sustained
// rate of one transfer per cycle while m_tready is high. A byte passes through the classifying
// register, the two-entry queue and the result register; the back end updates the parsing
// state and length counters for each byte it takes, which sets the rate. Stalls on the result
// side fill the queue before the input side is held off.
module imap_astring_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte[7:0]
  input  logic [1:0]  s_tuser,   // start_req[0], list_mode[1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // data_byte[7:0], length[39:8]
  output logic [3:0]  m_tuser    // status[1:0], data_valid[2], byte_consumed[3]
);
  import iasp_pkg::*;

  item_t                   front_item;
  item_t                   queue_item;
  logic                    front_valid;
  logic                    front_ready;
  logic                    queue_valid;
  logic                    queue_ready;
  logic [1:0]              status;
  logic                    data_valid;
  logic [7:0]              data_byte;
  logic [LEN_OUT_BITS-1:0] length;
  logic                    byte_consumed;

  iasp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .start_req  (s_tuser[0]),
    .list_mode  (s_tuser[1]),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  iasp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_item  (front_item),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .rd_item  (queue_item)
  );

  iasp_exec u_exec (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (queue_valid),
    .item_ready    (queue_ready),
    .item          (queue_item),
    .res_valid     (m_tvalid),
    .res_ready     (m_tready),
    .status        (status),
    .data_valid    (data_valid),
    .data_byte     (data_byte),
    .length        (length),
    .byte_consumed (byte_consumed)
  );

  assign m_tdata = {length, data_byte};
  assign m_tuser = {byte_consumed, data_valid, status};

endmodule

// ===== rtl/core/iasp_front.sv =====
// Front end: accepts raw bytes, classifies them and registers the result.
module iasp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               start_req,
  input  logic               list_mode,
  output logic               item_valid,
  input  logic               item_ready,
  output iasp_pkg::item_t    item
);
  import iasp_pkg::*;

  item_t cls_item;
  logic  in_range;
  logic  illegal_any;
  logic  pct_star;

  always_comb begin
    cls_item                = '0;
    cls_item.byte_val       = in_byte;
    cls_item.start_req      = start_req;
    cls_item.list_mode      = list_mode;
    cls_item.digit          = 4'(in_byte - CH_ZERO);
    in_range    = (in_byte >= ATOM_LO) && (in_byte <= ATOM_HI);
    illegal_any = (in_byte == CH_LPAREN) || (in_byte == CH_RPAREN) ||
                  (in_byte == CH_LBRACE) || (in_byte == CH_QUOTE) ||
                  (in_byte == CH_BSLASH);
    pct_star    = (in_byte == CH_PCT) || (in_byte == CH_STAR);
    cls_item.atom_strict    = in_range && !illegal_any && !pct_star;
    cls_item.atom_list_only = pct_star;
    if (in_byte == CH_LBRACE) begin
      cls_item.cls = CLS_LBRACE;
    end else if (in_byte == CH_RBRACE) begin
      cls_item.cls = CLS_RBRACE;
    end else if (in_byte == CH_PLUS) begin
      cls_item.cls = CLS_PLUS;
    end else if (in_byte == CH_QUOTE) begin
      cls_item.cls = CLS_QUOTE;
    end else if (in_byte == CH_BSLASH) begin
      cls_item.cls = CLS_BSLASH;
    end else if ((in_byte >= CH_ZERO) && (in_byte <= CH_NINE)) begin
      cls_item.cls = CLS_DIGIT;
    end else if (in_byte == CH_NUL) begin
      cls_item.cls = CLS_NUL;
    end else if ((in_byte == CH_CR) || (in_byte == CH_LF)) begin
      cls_item.cls = CLS_CRLF;
    end else begin
      cls_item.cls = CLS_OTHER;
    end
  end

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= cls_item;
    end
  end

endmodule

// ===== rtl/core/iasp_queue.sv =====
// Short first-in first-out queue of classified items between front and back.
module iasp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  iasp_pkg::item_t    wr_item,
  output logic               rd_valid,
  input  logic               rd_ready,
  output iasp_pkg::item_t    rd_item
);
  import iasp_pkg::*;

  item_t                entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 push;
  logic                 pop;

  assign wr_ready = (count != QCNT_BITS'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

// ===== rtl/core/iasp_exec.sv =====
// Back end: the parsing state machine, length counters and result register.
module iasp_exec (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  iasp_pkg::item_t                 item,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [1:0]                      status,
  output logic                            data_valid,
  output logic [7:0]                      data_byte,
  output logic [iasp_pkg::LEN_OUT_BITS-1:0] length,
  output logic                            byte_consumed
);
  import iasp_pkg::*;

  phase_t                 phase;
  phase_t                 phase_next;
  phase_t                 phase_eff;
  phase_t                 phase_step;
  logic [LENGTH_BITS-1:0] content_count;
  logic [LENGTH_BITS-1:0] content_count_next;
  logic [LENGTH_BITS-1:0] literal_remaining;
  logic [LENGTH_BITS-1:0] literal_remaining_next;
  logic                   list_mode_held;
  logic                   list_mode_held_next;
  logic [LENGTH_BITS-1:0] cnt_eff;
  logic [LENGTH_BITS-1:0] rem_eff;
  logic [LENGTH_BITS-1:0] cnt_inc;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic [WIDE_BITS-1:0]   digit_wide;
  logic [LENGTH_BITS-1:0] cnt_digit;
  logic [63:0]            len_wide;
  logic                   is_atom;
  logic                   fire;
  logic                   err;
  logic                   done;
  logic                   valid_c;
  logic                   consumed_c;
  status_t                status_c;
  logic [7:0]             dbyte_c;
  logic [LEN_OUT_BITS-1:0] len_c;

  assign item_ready = !res_valid || res_ready;
  assign fire       = item_valid && item_ready;

  assign phase_eff           = item.start_req ? PH_START : phase;
  assign cnt_eff             = item.start_req ? '0 : content_count;
  assign rem_eff             = item.start_req ? '0 : literal_remaining;
  assign list_mode_held_next = item.start_req ? item.list_mode : list_mode_held;
  assign is_atom = item.atom_strict || (item.atom_list_only && list_mode_held_next);

  assign cnt_inc    = (&cnt_eff) ? cnt_eff : cnt_eff + 1'b1;
  assign rem_dec    = rem_eff - 1'b1;
  assign digit_wide = (WIDE_BITS'(cnt_eff) << 3) + (WIDE_BITS'(cnt_eff) << 1) +
                      WIDE_BITS'(item.digit);
  assign cnt_digit  = (|digit_wide[WIDE_BITS-1:LENGTH_BITS]) ? '1 :
                      digit_wide[LENGTH_BITS-1:0];

  // Next state and counters.
  always_comb begin
    phase_step             = phase_eff;
    content_count_next     = cnt_eff;
    literal_remaining_next = rem_eff;
    case (phase_eff)
      PH_START: begin
        if (item.cls == CLS_LBRACE) begin
          phase_step = PH_LIT_FIRST;
        end else if (item.cls == CLS_QUOTE) begin
          phase_step = PH_QUOTED;
        end else if (is_atom) begin
          content_count_next = LENGTH_BITS'(1);
          phase_step         = PH_ATOM;
        end
      end
      PH_LIT_FIRST, PH_LIT_DIGITS: begin
        if (item.cls == CLS_DIGIT) begin
          content_count_next = cnt_digit;
          phase_step         = PH_LIT_DIGITS;
        end else if (phase_eff == PH_LIT_DIGITS && item.cls == CLS_PLUS) begin
          phase_step = PH_LIT_CLOSE;
        end else if (phase_eff == PH_LIT_DIGITS && item.cls == CLS_RBRACE) begin
          phase_step = PH_LIT_PLUS;
        end
      end
      PH_LIT_CLOSE: begin
        if (item.cls == CLS_RBRACE) begin
          phase_step = PH_LIT_PLUS;
        end
      end
      PH_LIT_PLUS: begin
        if (item.cls == CLS_PLUS && cnt_eff != '0) begin
          literal_remaining_next = cnt_eff;
          phase_step             = PH_LIT_DATA;
        end
      end
      PH_LIT_DATA: begin
        if (item.cls != CLS_NUL) begin
          literal_remaining_next = rem_dec;
        end
      end
      PH_QUOTED: begin
        if (item.cls == CLS_BSLASH) begin
          phase_step = PH_QUOTED_ESC;
        end else if (item.cls != CLS_QUOTE && item.cls != CLS_NUL &&
                     item.cls != CLS_CRLF) begin
          content_count_next = cnt_inc;
        end
      end
      PH_QUOTED_ESC: begin
        if (item.cls == CLS_BSLASH || item.cls == CLS_QUOTE) begin
          content_count_next = cnt_inc;
          phase_step         = PH_QUOTED;
        end
      end
      PH_ATOM: begin
        if (is_atom) begin
          content_count_next = cnt_inc;
        end
      end
      default: begin
        phase_step = PH_IDLE;
      end
    endcase
    phase_next = (err || done) ? PH_IDLE : phase_step;
  end

  // Result fields.
  always_comb begin
    err        = 1'b0;
    done       = 1'b0;
    valid_c    = 1'b0;
    consumed_c = 1'b1;
    case (phase_eff)
      PH_START: begin
        if (item.cls != CLS_LBRACE && item.cls != CLS_QUOTE) begin
          if (is_atom) begin
            valid_c = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
      end
      PH_LIT_FIRST, PH_LIT_DIGITS: begin
        if (item.cls != CLS_DIGIT &&
            !(phase_eff == PH_LIT_DIGITS &&
              (item.cls == CLS_PLUS || item.cls == CLS_RBRACE))) begin
          err = 1'b1;
        end
      end
      PH_LIT_CLOSE: begin
        err = (item.cls != CLS_RBRACE);
      end
      PH_LIT_PLUS: begin
        if (item.cls != CLS_PLUS) begin
          err = 1'b1;
        end else if (cnt_eff == '0) begin
          done = 1'b1;
        end
      end
      PH_LIT_DATA: begin
        if (item.cls == CLS_NUL) begin
          err = 1'b1;
        end else begin
          valid_c = 1'b1;
          done    = (rem_dec == '0);
        end
      end
      PH_QUOTED: begin
        if (item.cls == CLS_QUOTE) begin
          done = 1'b1;
        end else if (item.cls == CLS_NUL || item.cls == CLS_CRLF) begin
          err = 1'b1;
        end else if (item.cls != CLS_BSLASH) begin
          valid_c = 1'b1;
        end
      end
      PH_QUOTED_ESC: begin
        if (item.cls == CLS_BSLASH || item.cls == CLS_QUOTE) begin
          valid_c = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      PH_ATOM: begin
        if (is_atom) begin
          valid_c = 1'b1;
        end else begin
          consumed_c = 1'b0;
          done       = 1'b1;
        end
      end
      default: begin
        err        = 1'b1;
        consumed_c = 1'b0;
      end
    endcase
    if (err) begin
      valid_c = 1'b0;
    end
    status_c = err ? ST_ERR : (done ? ST_DONE : ST_MORE);
    dbyte_c  = valid_c ? item.byte_val : 8'h00;
    len_wide = 64'(content_count_next);
    if (err) begin
      len_c = '0;
    end else if (|len_wide[63:LEN_OUT_BITS]) begin
      len_c = '1;
    end else begin
      len_c = len_wide[LEN_OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      content_count     <= '0;
      literal_remaining <= '0;
      list_mode_held    <= 1'b0;
      res_valid         <= 1'b0;
    end else begin
      if (fire) begin
        phase             <= phase_next;
        content_count     <= content_count_next;
        literal_remaining <= literal_remaining_next;
        list_mode_held    <= list_mode_held_next;
      end
      if (item_ready) begin
        res_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status        <= status_c;
      data_valid    <= valid_c;
      data_byte     <= dbyte_c;
      length        <= len_c;
      byte_consumed <= consumed_c;
    end
  end

endmodule
